// ===== rtl/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// dpq_pkg - shared definitions for the dual pot hysteresis quantiser
// Widths, microcode field codes, control/flag structs and the endpoint table.
// ----------------------------------------------------------------------------
`default_nettype none

package dpq_pkg;

  localparam int NUM_LEVELS = 21;
  localparam int LVL_W      = 5;
  localparam int ADC_W      = 10;
  localparam int MARGIN_W   = 6;
  localparam int OUT_W      = 5;
  localparam int PC_W       = 3;

  localparam logic [OUT_W-1:0]    OUT_BASE     = 5'd10;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 6'd15;
  localparam logic [LVL_W-1:0]    TOP_LEVEL    = 5'(NUM_LEVELS - 1);

  // condition select
  localparam logic [2:0] COND_ALWAYS   = 3'd0;
  localparam logic [2:0] COND_IN_ACC   = 3'd1;
  localparam logic [2:0] COND_FIRST    = 3'd2;
  localparam logic [2:0] COND_IN_BAND  = 3'd3;
  localparam logic [2:0] COND_SCAN_HIT = 3'd4;
  localparam logic [2:0] COND_CH0      = 3'd5;
  localparam logic [2:0] COND_OUT_FREE = 3'd6;

  // datapath operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_CAPTURE = 3'd1;
  localparam logic [2:0] OP_CLR_K   = 3'd2;
  localparam logic [2:0] OP_SCAN    = 3'd3;
  localparam logic [2:0] OP_NEXT    = 3'd4;
  localparam logic [2:0] OP_EMIT    = 3'd5;

  // program steps
  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_FIRST = 3'd1;
  localparam logic [PC_W-1:0] STEP_BAND  = 3'd2;
  localparam logic [PC_W-1:0] STEP_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] STEP_NEXT  = 3'd4;
  localparam logic [PC_W-1:0] STEP_EMIT  = 3'd5;

  typedef struct packed {
    logic [2:0]      cond;
    logic [2:0]      op;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } dpq_ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic first;
    logic in_band;
    logic scan_hit;
    logic ch0;
    logic out_free;
  } dpq_flags_t;

  function automatic logic [ADC_W-1:0] edge_at(input logic [LVL_W-1:0] idx);
    logic [ADC_W-1:0] v;
    case (idx)
      5'd0:    v = 10'd0;
      5'd1:    v = 10'd49;
      5'd2:    v = 10'd97;
      5'd3:    v = 10'd146;
      5'd4:    v = 10'd195;
      5'd5:    v = 10'd244;
      5'd6:    v = 10'd292;
      5'd7:    v = 10'd341;
      5'd8:    v = 10'd390;
      5'd9:    v = 10'd438;
      5'd10:   v = 10'd487;
      5'd11:   v = 10'd536;
      5'd12:   v = 10'd585;
      5'd13:   v = 10'd633;
      5'd14:   v = 10'd682;
      5'd15:   v = 10'd731;
      5'd16:   v = 10'd779;
      5'd17:   v = 10'd828;
      5'd18:   v = 10'd877;
      5'd19:   v = 10'd926;
      5'd20:   v = 10'd974;
      default: v = 10'd1023;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpq_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// dpq_ucode_rom - control store
// One control word per program step: condition, operation, two jump targets.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_ucode_rom (
  input  wire logic [dpq_pkg::PC_W-1:0] pc,
  output dpq_pkg::dpq_ctrl_t            ctrl
);

  always_comb begin
    case (pc)
      dpq_pkg::STEP_IDLE: begin
        ctrl = '{dpq_pkg::COND_IN_ACC, dpq_pkg::OP_CAPTURE,
                 dpq_pkg::STEP_FIRST, dpq_pkg::STEP_IDLE};
      end
      dpq_pkg::STEP_FIRST: begin
        ctrl = '{dpq_pkg::COND_FIRST, dpq_pkg::OP_CLR_K,
                 dpq_pkg::STEP_SCAN, dpq_pkg::STEP_BAND};
      end
      dpq_pkg::STEP_BAND: begin
        ctrl = '{dpq_pkg::COND_IN_BAND, dpq_pkg::OP_NONE,
                 dpq_pkg::STEP_NEXT, dpq_pkg::STEP_SCAN};
      end
      dpq_pkg::STEP_SCAN: begin
        ctrl = '{dpq_pkg::COND_SCAN_HIT, dpq_pkg::OP_SCAN,
                 dpq_pkg::STEP_NEXT, dpq_pkg::STEP_SCAN};
      end
      dpq_pkg::STEP_NEXT: begin
        ctrl = '{dpq_pkg::COND_CH0, dpq_pkg::OP_NEXT,
                 dpq_pkg::STEP_FIRST, dpq_pkg::STEP_EMIT};
      end
      dpq_pkg::STEP_EMIT: begin
        ctrl = '{dpq_pkg::COND_OUT_FREE, dpq_pkg::OP_EMIT,
                 dpq_pkg::STEP_IDLE, dpq_pkg::STEP_EMIT};
      end
      default: begin
        ctrl = '{dpq_pkg::COND_ALWAYS, dpq_pkg::OP_NONE,
                 dpq_pkg::STEP_IDLE, dpq_pkg::STEP_IDLE};
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dpq_datapath.sv =====
// ----------------------------------------------------------------------------
// dpq_datapath - readings, levels, scan index, margin and output word
// Executes one operation per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [2:0]                    op,
  input  wire logic                          cond_true,
  output dpq_pkg::dpq_flags_t                flags,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dpq_pkg::ADC_W-1:0]     in_rate_pot_level,
  input  wire logic [dpq_pkg::ADC_W-1:0]     in_ratio_pot_level,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dpq_pkg::OUT_W-1:0]          out_breaths_per_minute,
  output logic [dpq_pkg::OUT_W-1:0]          out_ratio_tenths,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dpq_pkg::MARGIN_W-1:0]  cfg_hysteresis_margin
);

  logic [dpq_pkg::ADC_W-1:0]    rate_rd_r, ratio_rd_r;
  logic [dpq_pkg::LVL_W-1:0]    rate_lvl_r, ratio_lvl_r, rate_lvl_nxt, ratio_lvl_nxt;
  logic [dpq_pkg::LVL_W-1:0]    k_r, k_nxt;
  logic                         ch_r, ch_nxt;
  logic                         first_r, first_nxt;
  logic [dpq_pkg::MARGIN_W-1:0] margin_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [dpq_pkg::OUT_W-1:0]    bpm_r, ratio_r;

  logic [dpq_pkg::ADC_W-1:0]    cur_rd, lo_base, lo, scan_lo, scan_hi, margin_x;
  logic [dpq_pkg::LVL_W-1:0]    cur_lvl, lvl_c;
  logic [dpq_pkg::ADC_W:0]      hi;
  logic                         in_acc, out_free;

  assign in_stall  = (op != dpq_pkg::OP_CAPTURE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign cur_rd   = ch_r ? ratio_rd_r : rate_rd_r;
  assign cur_lvl  = ch_r ? ratio_lvl_r : rate_lvl_r;
  assign lvl_c    = (cur_lvl > dpq_pkg::TOP_LEVEL) ? dpq_pkg::TOP_LEVEL : cur_lvl;
  assign margin_x = {{(dpq_pkg::ADC_W-dpq_pkg::MARGIN_W){1'b0}}, margin_r};

  // widened band around the current level; lower edge of level 0 stays put
  always_comb begin
    lo_base = dpq_pkg::edge_at(lvl_c);
    if (lvl_c == '0) begin
      lo = lo_base;
    end else if (lo_base > margin_x) begin
      lo = lo_base - margin_x;
    end else begin
      lo = '0;
    end
    hi = {1'b0, dpq_pkg::edge_at(lvl_c + 5'd1)} + {1'b0, margin_x};
  end

  assign scan_lo = dpq_pkg::edge_at(k_r);
  assign scan_hi = dpq_pkg::edge_at(k_r + 5'd1);

  assign flags.in_acc   = in_acc;
  assign flags.first    = first_r;
  assign flags.in_band  = (cur_rd >= lo) && ({1'b0, cur_rd} <= hi);
  assign flags.scan_hit = ((cur_rd >= scan_lo) && (cur_rd <= scan_hi)) ||
                          (k_r >= dpq_pkg::TOP_LEVEL);
  assign flags.ch0      = !ch_r;
  assign flags.out_free = out_free;

  always_comb begin
    rate_lvl_nxt  = rate_lvl_r;
    ratio_lvl_nxt = ratio_lvl_r;
    k_nxt         = k_r;
    ch_nxt        = ch_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (op)
      dpq_pkg::OP_CAPTURE: begin
        if (cond_true) ch_nxt = 1'b0;
      end
      dpq_pkg::OP_CLR_K: begin
        k_nxt = '0;
      end
      dpq_pkg::OP_SCAN: begin
        if (cond_true) begin
          if (ch_r) ratio_lvl_nxt = k_r;
          else      rate_lvl_nxt  = k_r;
        end else begin
          k_nxt = k_r + 5'd1;
        end
      end
      dpq_pkg::OP_NEXT: begin
        if (cond_true) ch_nxt = 1'b1;
      end
      dpq_pkg::OP_EMIT: begin
        if (cond_true) begin
          out_valid_nxt = 1'b1;
          first_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_lvl_r  <= '0;
      ratio_lvl_r <= '0;
      k_r         <= '0;
      ch_r        <= 1'b0;
      first_r     <= 1'b1;
      margin_r    <= dpq_pkg::MARGIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      rate_lvl_r  <= rate_lvl_nxt;
      ratio_lvl_r <= ratio_lvl_nxt;
      k_r         <= k_nxt;
      ch_r        <= ch_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) margin_r <= cfg_hysteresis_margin;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate_rd_r  <= in_rate_pot_level;
      ratio_rd_r <= in_ratio_pot_level;
    end
    if (op == dpq_pkg::OP_EMIT && cond_true) begin
      bpm_r   <= dpq_pkg::OUT_BASE + rate_lvl_r;
      ratio_r <= dpq_pkg::OUT_BASE + ratio_lvl_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_breaths_per_minute = bpm_r;
  assign out_ratio_tenths       = ratio_r;

endmodule

`default_nettype wire

// ===== rtl/dual_pot_hysteresis_quantizer_top.sv =====
// ----------------------------------------------------------------------------
// dual_pot_hysteresis_quantizer_top - two-channel pot quantiser with hysteresis
// Microcoded sequencer: step counter, control store and condition select.
// Steps: capture in idle; per channel, a band check or, on the first word or
//   a band miss, a scan testing one level per cycle; then emit once the
//   output is free. One word in flight at a time.
// Reset (rst_n, synchronous): levels 0, first-word flag set, margin 15, idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_pot_hysteresis_quantizer_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [9:0] in_rate_pot_level,
  input  wire logic [9:0] in_ratio_pot_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [4:0]      out_breaths_per_minute,
  output logic [4:0]      out_ratio_tenths,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_hysteresis_margin
);

  logic [dpq_pkg::PC_W-1:0] pc_r, pc_nxt;
  dpq_pkg::dpq_ctrl_t       ctrl;
  dpq_pkg::dpq_flags_t      flags;
  logic                     cond_true;

  dpq_ucode_rom u_rom (
    .pc   (pc_r),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      dpq_pkg::COND_ALWAYS:   cond_true = 1'b1;
      dpq_pkg::COND_IN_ACC:   cond_true = flags.in_acc;
      dpq_pkg::COND_FIRST:    cond_true = flags.first;
      dpq_pkg::COND_IN_BAND:  cond_true = flags.in_band;
      dpq_pkg::COND_SCAN_HIT: cond_true = flags.scan_hit;
      dpq_pkg::COND_CH0:      cond_true = flags.ch0;
      dpq_pkg::COND_OUT_FREE: cond_true = flags.out_free;
      default:                cond_true = 1'b1;
    endcase
  end

  assign pc_nxt = cond_true ? ctrl.tgt_t : ctrl.tgt_f;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= dpq_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  dpq_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .op                     (ctrl.op),
    .cond_true              (cond_true),
    .flags                  (flags),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rate_pot_level      (in_rate_pot_level),
    .in_ratio_pot_level     (in_ratio_pot_level),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_breaths_per_minute (out_breaths_per_minute),
    .out_ratio_tenths       (out_ratio_tenths),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_hysteresis_margin  (cfg_hysteresis_margin)
  );

  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (pc_r == dpq_pkg::STEP_IDLE))
    else $error("word accepted outside idle step");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(pc_r) == dpq_pkg::STEP_EMIT))
    else $error("result raised outside emit step");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_breaths_per_minute >= 5'd10 && out_breaths_per_minute <= 5'd30 &&
                   out_ratio_tenths >= 5'd10 && out_ratio_tenths <= 5'd30))
    else $error("result out of range");

  a_pc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r <= dpq_pkg::STEP_EMIT))
    else $error("sequencer off program");

endmodule

`default_nettype wire

// ===== verif/dual_pot_hysteresis_quantizer_top_test.sv =====
// ----------------------------------------------------------------------------
// dual_pot_hysteresis_quantizer_top_test - self-checking bench for the quantiser
// Feeds pot reading pairs through a stall-driven driver, tracks both channel
// levels with a band/hysteresis predictor and checks every output word in order.
// Margin is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_pot_hysteresis_quantizer_top_test;

  typedef struct {
    logic [dpq_pkg::ADC_W-1:0] rate;
    logic [dpq_pkg::ADC_W-1:0] ratio;
  } pot_pair_t;

  typedef struct {
    logic [dpq_pkg::OUT_W-1:0] bpm;
    logic [dpq_pkg::OUT_W-1:0] ratio;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [dpq_pkg::ADC_W-1:0]    in_rate_pot_level = '0;
  logic [dpq_pkg::ADC_W-1:0]    in_ratio_pot_level = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [dpq_pkg::OUT_W-1:0]    out_breaths_per_minute;
  logic [dpq_pkg::OUT_W-1:0]    out_ratio_tenths;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dpq_pkg::MARGIN_W-1:0] cfg_hysteresis_margin = '0;

  dual_pot_hysteresis_quantizer_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_rate_pot_level      (in_rate_pot_level),
    .in_ratio_pot_level     (in_ratio_pot_level),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_breaths_per_minute (out_breaths_per_minute),
    .out_ratio_tenths       (out_ratio_tenths),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_hysteresis_margin  (cfg_hysteresis_margin)
  );

  always #10 clk = ~clk;

  logic [dpq_pkg::ADC_W-1:0] band_ends [0:dpq_pkg::NUM_LEVELS] = '{
    10'd0, 10'd49, 10'd97, 10'd146, 10'd195, 10'd244, 10'd292, 10'd341,
    10'd390, 10'd438, 10'd487, 10'd536, 10'd585, 10'd633, 10'd682, 10'd731,
    10'd779, 10'd828, 10'd877, 10'd926, 10'd974, 10'd1023
  };

  pot_pair_t pots_to_send [$];
  setting_t  settings_due [$];

  logic [dpq_pkg::MARGIN_W-1:0] quant_margin = dpq_pkg::MARGIN_RESET;
  logic [dpq_pkg::LVL_W-1:0]    rate_lvl = '0;
  logic [dpq_pkg::LVL_W-1:0]    ratio_lvl = '0;
  logic                         awaiting_first = 1'b1;

  int  send_idle_max = 18;
  int  recv_idle_max = 18;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  error_count = 0;
  int  rx_hold_left = 0;
  logic rx_hold_start = 1'b0;
  logic [dpq_pkg::ADC_W-1:0] last_rate = '0;
  logic [dpq_pkg::ADC_W-1:0] last_ratio = '0;

  // lowest band holding the reading, so shared edges go down
  function automatic logic [dpq_pkg::LVL_W-1:0] scan_band(
      input logic [dpq_pkg::ADC_W-1:0] rd);
    for (int k = 0; k < dpq_pkg::NUM_LEVELS; k++) begin
      if (rd >= band_ends[k] && rd <= band_ends[k+1]) return dpq_pkg::LVL_W'(k);
    end
    return dpq_pkg::TOP_LEVEL;
  endfunction

  function automatic logic [dpq_pkg::LVL_W-1:0] track_level(
      input logic [dpq_pkg::LVL_W-1:0]    lvl,
      input logic [dpq_pkg::ADC_W-1:0]    rd,
      input logic [dpq_pkg::MARGIN_W-1:0] m);
    logic [dpq_pkg::LVL_W-1:0] l;
    logic [dpq_pkg::ADC_W:0]   lo;
    logic [dpq_pkg::ADC_W:0]   hi;
    l = (lvl >= dpq_pkg::NUM_LEVELS) ? dpq_pkg::TOP_LEVEL : lvl;
    lo = {1'b0, band_ends[l]};
    if (l != 0) lo = (lo > m) ? lo - m : '0;
    hi = {1'b0, band_ends[l+1]} + m;
    if (rd < lo || rd > hi) return scan_band(rd);
    return l;
  endfunction

  function automatic void quantise_pair(input logic [dpq_pkg::ADC_W-1:0] rate,
                                        input logic [dpq_pkg::ADC_W-1:0] ratio);
    setting_t s;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      rate_lvl  = scan_band(rate);
      ratio_lvl = scan_band(ratio);
    end else begin
      rate_lvl  = track_level(rate_lvl, rate, quant_margin);
      ratio_lvl = track_level(ratio_lvl, ratio, quant_margin);
    end
    s.bpm   = dpq_pkg::OUT_BASE + rate_lvl;
    s.ratio = dpq_pkg::OUT_BASE + ratio_lvl;
    settings_due.push_back(s);
  endfunction

  // driver
  always @(posedge clk) begin
    pot_pair_t p;
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        quantise_pair(in_rate_pot_level, in_ratio_pot_level);
        send_wait = int'($urandom_range(0, send_idle_max));
      end
      if (!in_valid || taken) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pots_to_send.size() != 0) begin
          p = pots_to_send.pop_front();
          in_valid <= 1'b1;
          in_rate_pot_level <= p.rate;
          in_ratio_pot_level <= p.ratio;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) rx_hold_left <= 0;
    else if (rx_hold_start) rx_hold_left <= 400;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  // monitor
  always @(posedge clk) begin
    setting_t s;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (settings_due.size() == 0) begin
          $display("%0t: unexpected word, got bpm %0d ratio %0d", $time,
                   out_breaths_per_minute, out_ratio_tenths);
          error_count++;
        end else begin
          s = settings_due.pop_front();
          if (out_breaths_per_minute !== s.bpm) begin
            $display("%0t: breaths_per_minute expected %0d, got %0d", $time,
                     s.bpm, out_breaths_per_minute);
            error_count++;
          end
          if (out_ratio_tenths !== s.ratio) begin
            $display("%0t: ratio_tenths expected %0d, got %0d", $time,
                     s.ratio, out_ratio_tenths);
            error_count++;
          end
        end
        recv_wait = int'($urandom_range(0, recv_idle_max));
      end
      if (rx_hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // half the readings close to a band end, within reach of the margin
  function automatic logic [dpq_pkg::ADC_W-1:0] pick_reading(
      input logic [dpq_pkg::ADC_W-1:0] prev,
      input int                        slack);
    int choice;
    int v;
    choice = int'($urandom_range(0, 9));
    if (choice < 3)
      v = int'($urandom_range(0, 1023));
    else if (choice < 8)
      v = int'(band_ends[$urandom_range(0, dpq_pkg::NUM_LEVELS)])
          + int'($urandom_range(0, 2 * slack + 6)) - slack - 3;
    else
      v = int'(prev) + int'($urandom_range(0, 2 * slack + 8)) - slack - 4;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[dpq_pkg::ADC_W-1:0];
  endfunction

  task automatic queue_pair(input int rate, input int ratio);
    pot_pair_t p;
    p.rate  = dpq_pkg::ADC_W'(rate);
    p.ratio = dpq_pkg::ADC_W'(ratio);
    pots_to_send.push_back(p);
  endtask

  task automatic wait_idle();
    while (pots_to_send.size() != 0 || in_valid || settings_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_margin(input logic [dpq_pkg::MARGIN_W-1:0] m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_hysteresis_margin <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    quant_margin = m;
  endtask

  task automatic run_phase(input int n, input int send_max, input int recv_max,
                           input bit hold_rx);
    @(negedge clk);
    send_idle_max = send_max;
    recv_idle_max = recv_max;
    for (int i = 0; i < n; i++) begin
      last_rate  = pick_reading(last_rate, int'(quant_margin));
      last_ratio = pick_reading(last_ratio, int'(quant_margin));
      queue_pair(int'(last_rate), int'(last_ratio));
    end
    if (hold_rx) begin
      @(posedge clk);
      rx_hold_start <= 1'b1;
      @(posedge clk);
      rx_hold_start <= 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // first word takes a plain scan; edges go to the lower band
    @(negedge clk);
    queue_pair(49, 974);
    queue_pair(64, 989);
    queue_pair(65, 990);
    queue_pair(34, 959);
    queue_pair(33, 958);
    queue_pair(0, 1023);
    queue_pair(1023, 0);
    queue_pair(97, 146);
    queue_pair(512, 512);
    queue_pair(536, 487);
    queue_pair(552, 471);
    queue_pair(682, 341);
    queue_pair(1023, 1023);
    queue_pair(0, 0);
    queue_pair(511, 1022);
    queue_pair(512, 1);
    queue_pair(341, 682);
    queue_pair(926, 49);
    wait_idle();

    run_phase(240, 18, 18, 1'b1);
    write_margin(6'd0);
    run_phase(240, 0, 0, 1'b0);
    // margin 63: lower edges near zero saturate at zero
    write_margin(6'd63);
    run_phase(240, 18, 18, 1'b0);
    write_margin(6'd48);
    run_phase(240, 5, 18, 1'b0);
    write_margin(6'd1);
    run_phase(220, 18, 0, 1'b0);
    write_margin(dpq_pkg::MARGIN_W'($urandom_range(0, 48)));
    run_phase(220, 18, 18, 1'b1);
    write_margin(dpq_pkg::MARGIN_W'($urandom_range(0, 63)));
    run_phase(200, 0, 18, 1'b0);
    write_margin(dpq_pkg::MARGIN_RESET);
    run_phase(200, 18, 18, 1'b0);

    repeat (60) @(posedge clk);
    if (error_count == 0 && settings_due.size() == 0)
      $display("dual_pot_hysteresis_quantizer_top_test: done, clean");
    else
      $display("dual_pot_hysteresis_quantizer_top_test: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("dual_pot_hysteresis_quantizer_top_test: done, errors");
    $finish;
  end

endmodule
